// ----- rtl/ps2mc_pkg.sv -----
`default_nettype none
package ps2mc_pkg;

  localparam int POS_WIDTH_DEF = 12;
  localparam int SCREEN_W      = 12;
  localparam int CURSOR_W      = 12;
  localparam int BUTTON_W      = 3;
  localparam int BYTE_W        = 8;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_TDATA_W   = 32;
  localparam int CFG_INDEX_W   = 1;

  localparam logic [BYTE_W-1:0] SYNC_BIT      = 8'h08;
  localparam logic [BYTE_W-1:0] OVERFLOW_BITS = 8'hC0;
  localparam logic [BYTE_W-1:0] BUTTON_MASK   = 8'h07;
  localparam int                X_SIGN_POS    = 4;
  localparam int                Y_SIGN_POS    = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 12'd320;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 12'd200;
  localparam int                  POS_X_RST         = 160;
  localparam int                  POS_Y_RST         = 100;

  typedef enum logic [1:0] {
    PH_FLAGS  = 2'd0,
    PH_XDELTA = 2'd1,
    PH_YDELTA = 2'd2
  } phase_t;

endpackage
`default_nettype wire

// ----- rtl/ps2_mouse_packet_cursor.sv -----
`default_nettype none
// out_tvalid rises in the cycle after the beat carrying the third packet byte is taken.
// Throughput: one byte beat per cycle while the result register is empty or being drained.
// Packets dropped for sync or overflow produce no result beat.
// Reset (rst_n low at a rising edge): phase awaits a flags byte, cursor returns to
// 160/100, buttons clear, screen bounds return to 320 by 200, result register empties.
module ps2_mouse_packet_cursor #(
  parameter int POS_WIDTH = ps2mc_pkg::POS_WIDTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  input  wire  [ps2mc_pkg::IN_TDATA_W-1:0]      in_tdata,   // data_byte
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  output logic [ps2mc_pkg::OUT_TDATA_W-1:0]     out_tdata,  // cursor_x, cursor_y, button_bits
  input  wire                                   cfg_we,
  input  wire  [ps2mc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [ps2mc_pkg::SCREEN_W-1:0]        cfg_wdata
);

  localparam int CW = ((POS_WIDTH > ps2mc_pkg::SCREEN_W) ? POS_WIDTH : ps2mc_pkg::SCREEN_W) + 2;
  localparam logic signed [CW-1:0] POS_MAX = CW'((2 ** POS_WIDTH) - 1);
  localparam int OUT_PAD = ps2mc_pkg::OUT_TDATA_W - 2 * ps2mc_pkg::CURSOR_W - ps2mc_pkg::BUTTON_W;

  ps2mc_pkg::phase_t phase_r, phase_nxt;
  logic [ps2mc_pkg::BYTE_W-1:0]   flags_r, flags_nxt;
  logic [ps2mc_pkg::BYTE_W-1:0]   xbyte_r, xbyte_nxt;
  logic [POS_WIDTH-1:0]           pos_x_r, pos_x_nxt;
  logic [POS_WIDTH-1:0]           pos_y_r, pos_y_nxt;
  logic [ps2mc_pkg::BUTTON_W-1:0] buttons_r, buttons_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [ps2mc_pkg::SCREEN_W-1:0] width_r, height_r;

  logic                           in_acc;
  logic [ps2mc_pkg::BYTE_W-1:0]   data;
  logic signed [CW-1:0]           dx, dy, new_x, new_y;
  logic [CW-1:0]                  px_ext, py_ext;

  function automatic logic [POS_WIDTH-1:0] clamp_pos(
    input logic signed [CW-1:0]        v,
    input logic [ps2mc_pkg::SCREEN_W-1:0] bound
  );
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] r;
    hi = signed'(CW'(bound)) - CW'(1);
    if (hi > POS_MAX) begin
      hi = POS_MAX;
    end
    r = v;
    if (r < 0) begin
      r = '0;
    end
    if (r > hi) begin
      r = hi;
    end
    if (bound == '0) begin
      r = '0;
    end
    return r[POS_WIDTH-1:0];
  endfunction

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign data      = in_tdata[ps2mc_pkg::BYTE_W-1:0];

  assign dx    = signed'({{(CW-ps2mc_pkg::BYTE_W){flags_r[ps2mc_pkg::X_SIGN_POS]}}, xbyte_r});
  assign dy    = signed'({{(CW-ps2mc_pkg::BYTE_W){flags_r[ps2mc_pkg::Y_SIGN_POS]}}, data});
  assign new_x = signed'(CW'(pos_x_r)) + dx;
  assign new_y = signed'(CW'(pos_y_r)) - dy;

  always_comb begin
    phase_nxt     = phase_r;
    flags_nxt     = flags_r;
    xbyte_nxt     = xbyte_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    buttons_nxt   = buttons_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (in_acc) begin
      unique case (phase_r)
        ps2mc_pkg::PH_FLAGS: begin
          if ((data & ps2mc_pkg::SYNC_BIT) != '0) begin
            flags_nxt = data;
            phase_nxt = ps2mc_pkg::PH_XDELTA;
          end
        end
        ps2mc_pkg::PH_XDELTA: begin
          xbyte_nxt = data;
          phase_nxt = ps2mc_pkg::PH_YDELTA;
        end
        default: begin
          phase_nxt = ps2mc_pkg::PH_FLAGS;
          if ((flags_r & ps2mc_pkg::OVERFLOW_BITS) == '0) begin
            buttons_nxt   = flags_r[ps2mc_pkg::BUTTON_W-1:0];
            pos_x_nxt     = clamp_pos(new_x, width_r);
            pos_y_nxt     = clamp_pos(new_y, height_r);
            out_valid_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ps2mc_pkg::PH_FLAGS;
      flags_r     <= '0;
      xbyte_r     <= '0;
      pos_x_r     <= POS_WIDTH'(ps2mc_pkg::POS_X_RST);
      pos_y_r     <= POS_WIDTH'(ps2mc_pkg::POS_Y_RST);
      buttons_r   <= '0;
      out_valid_r <= 1'b0;
      width_r     <= ps2mc_pkg::SCREEN_WIDTH_RST;
      height_r    <= ps2mc_pkg::SCREEN_HEIGHT_RST;
    end else begin
      phase_r     <= phase_nxt;
      flags_r     <= flags_nxt;
      xbyte_r     <= xbyte_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      buttons_r   <= buttons_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ps2mc_pkg::REG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
          ps2mc_pkg::REG_SCREEN_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign px_ext     = CW'(pos_x_r);
  assign py_ext     = CW'(pos_y_r);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, buttons_r,
                       py_ext[ps2mc_pkg::CURSOR_W-1:0], px_ext[ps2mc_pkg::CURSOR_W-1:0]};

  a_result_from_packet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && !out_tready))
      |-> $past(in_acc && phase_r == ps2mc_pkg::PH_YDELTA))
    else $error("result beat without a completed packet");

  a_x_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((width_r == '0 && pos_x_r == '0) || (CW'(pos_x_r) < CW'(width_r))))
    else $error("cursor x outside screen");

  a_y_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((height_r == '0 && pos_y_r == '0) || (CW'(pos_y_r) < CW'(height_r))))
    else $error("cursor y outside screen");

  a_sync_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == ps2mc_pkg::PH_FLAGS && (data & ps2mc_pkg::SYNC_BIT) == '0)
      |=> phase_r == ps2mc_pkg::PH_FLAGS)
    else $error("unsynced flags byte accepted");

  a_x_to_y: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == ps2mc_pkg::PH_XDELTA) |=> phase_r == ps2mc_pkg::PH_YDELTA)
    else $error("phase did not advance after x byte");

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  localparam int IDLE_LIMIT = 3000;

  typedef struct packed {
    logic [ps2mc_pkg::CURSOR_W-1:0] x;
    logic [ps2mc_pkg::CURSOR_W-1:0] y;
    logic [ps2mc_pkg::BUTTON_W-1:0] buttons;
  } cursor_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n;
  logic                                 in_tvalid;
  logic                                 in_tready;
  logic [ps2mc_pkg::IN_TDATA_W-1:0]     in_tdata;   // data_byte
  logic                                 out_tvalid;
  logic                                 out_tready;
  logic [ps2mc_pkg::OUT_TDATA_W-1:0]    out_tdata;  // cursor_x, cursor_y, button_bits
  logic                                 cfg_we;
  logic [ps2mc_pkg::CFG_INDEX_W-1:0]    cfg_index;
  logic [ps2mc_pkg::SCREEN_W-1:0]       cfg_wdata;

  ps2mc_pkg::phase_t                    pkt_phase;
  logic [ps2mc_pkg::BYTE_W-1:0]         held_flags;
  logic [ps2mc_pkg::BYTE_W-1:0]         held_x;
  logic [ps2mc_pkg::CURSOR_W-1:0]       cur_x;
  logic [ps2mc_pkg::CURSOR_W-1:0]       cur_y;
  logic [ps2mc_pkg::BUTTON_W-1:0]       cur_buttons;
  logic [ps2mc_pkg::SCREEN_W-1:0]       screen_w_q;
  logic [ps2mc_pkg::SCREEN_W-1:0]       screen_h_q;
  cursor_t                              expected_cursor[$];

  int                      mismatches = 0;
  int                      burst_left = 0;
  bit                      tx_gaps = 1'b1;
  int unsigned             hold_req = 0;
  int unsigned             hold_left = 0;
  logic [15:0]             stall_pat = '1;
  logic [3:0]              pat_pos = '0;
  int                      idle_cycles = 0;

  ps2_mouse_packet_cursor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [ps2mc_pkg::CURSOR_W-1:0] clamp_to_screen(
    input int v,
    input logic [ps2mc_pkg::SCREEN_W-1:0] bound
  );
    int hi;
    if (bound == '0) return '0;
    hi = int'(bound) - 1;
    if (hi > (1 << ps2mc_pkg::CURSOR_W) - 1) hi = (1 << ps2mc_pkg::CURSOR_W) - 1;
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    return v[ps2mc_pkg::CURSOR_W-1:0];
  endfunction

  function automatic void track_mouse_byte(input logic [ps2mc_pkg::BYTE_W-1:0] b);
    int      dx;
    int      dy;
    cursor_t c;
    case (pkt_phase)
      ps2mc_pkg::PH_FLAGS: begin
        if ((b & ps2mc_pkg::SYNC_BIT) != '0) begin
          held_flags = b;
          pkt_phase  = ps2mc_pkg::PH_XDELTA;
        end
      end
      ps2mc_pkg::PH_XDELTA: begin
        held_x    = b;
        pkt_phase = ps2mc_pkg::PH_YDELTA;
      end
      default: begin
        pkt_phase = ps2mc_pkg::PH_FLAGS;
        if ((held_flags & ps2mc_pkg::OVERFLOW_BITS) == '0) begin
          cur_buttons = ps2mc_pkg::BUTTON_W'(held_flags & ps2mc_pkg::BUTTON_MASK);
          dx = $signed({held_flags[ps2mc_pkg::X_SIGN_POS], held_x});
          dy = $signed({held_flags[ps2mc_pkg::Y_SIGN_POS], b});
          cur_x = clamp_to_screen(int'(cur_x) + dx, screen_w_q);
          cur_y = clamp_to_screen(int'(cur_y) - dy, screen_h_q);
          c.x       = cur_x;
          c.y       = cur_y;
          c.buttons = cur_buttons;
          expected_cursor.push_back(c);
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // hold valid until the beat is taken; gaps fall between bursts
  task automatic send_byte(input logic [ps2mc_pkg::BYTE_W-1:0] b);
    int gap;
    if (tx_gaps && burst_left == 0) begin
      gap = $urandom_range(0, 5);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_mouse_byte(b);
    if (burst_left != 0) burst_left--;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_cursor.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_screen(input logic [ps2mc_pkg::SCREEN_W-1:0] w,
                            input logic [ps2mc_pkg::SCREEN_W-1:0] h);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= ps2mc_pkg::REG_SCREEN_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    screen_w_q = w;
    cfg_index <= ps2mc_pkg::REG_SCREEN_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    screen_h_q = h;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_mouse_traffic(input int packets);
    logic [ps2mc_pkg::BYTE_W-1:0] flags;
    logic [8:0]                   dx9;
    logic [8:0]                   dy9;
    int                           sel;
    for (int i = 0; i < packets; i++) begin
      sel = $urandom_range(0, 19);
      // stray byte: may knock the packet stream off alignment
      if (sel == 0) send_byte(ps2mc_pkg::BYTE_W'($urandom));
      flags = ps2mc_pkg::BYTE_W'($urandom);
      flags[3] = 1'b1;
      if (sel > 2) flags[7:6] = 2'b00;
      dx9 = $urandom_range(0, 1) ? 9'($urandom_range(0, 15)) - 9'd8 : 9'($urandom);
      dy9 = $urandom_range(0, 1) ? 9'($urandom_range(0, 15)) - 9'd8 : 9'($urandom);
      flags[ps2mc_pkg::X_SIGN_POS] = dx9[8];
      flags[ps2mc_pkg::Y_SIGN_POS] = dy9[8];
      send_byte(flags);
      send_byte(dx9[7:0]);
      send_byte(dy9[7:0]);
    end
  endtask

  task automatic test_reset_and_sync();
    send_byte(8'h00);
    send_byte(8'hF7);
    send_byte(8'h08);
    send_byte(8'h00);
    send_byte(8'h00);
  endtask

  task automatic test_delta_extremes();
    send_byte(8'h09); send_byte(8'hFF); send_byte(8'h00);
    send_byte(8'h3A); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h0C); send_byte(8'h7F); send_byte(8'hFF);
    send_byte(8'h2F); send_byte(8'h80); send_byte(8'h01);
  endtask

  task automatic test_overflow_packets();
    send_byte(8'h4F); send_byte(8'h10); send_byte(8'h10);
    send_byte(8'h88); send_byte(8'h55); send_byte(8'hAA);
    send_byte(8'h08); send_byte(8'h01); send_byte(8'h01);
  endtask

  task automatic test_random_traffic();
    tx_gaps = 1'b0;
    send_mouse_traffic(60);
    tx_gaps = 1'b1;
    send_mouse_traffic(90);
  endtask

  task automatic test_screen_bounds();
    set_screen(12'd1, 12'd1);
    send_mouse_traffic(30);
    set_screen(12'd4095, 12'd4095);
    send_mouse_traffic(30);
    set_screen(12'd0, 12'd0);
    send_mouse_traffic(30);
    set_screen(ps2mc_pkg::SCREEN_W'($urandom_range(1, 64)),
               ps2mc_pkg::SCREEN_W'($urandom_range(1, 4095)));
    send_mouse_traffic(30);
    set_screen(ps2mc_pkg::SCREEN_W'($urandom), ps2mc_pkg::SCREEN_W'($urandom));
    send_mouse_traffic(30);
    set_screen(ps2mc_pkg::SCREEN_WIDTH_RST, ps2mc_pkg::SCREEN_HEIGHT_RST);
    send_mouse_traffic(30);
  endtask

  task automatic test_output_stall();
    tx_gaps  = 1'b0;
    hold_req = 300;
    send_mouse_traffic(40);
    tx_gaps = 1'b1;
  endtask

  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (pat_pos == '0)
        stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
      out_tready <= stall_pat[pat_pos];
      pat_pos++;
    end
  end

  always @(posedge clk) begin
    cursor_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_cursor.size() == 0) begin
        report_mismatch("unexpected beat, cursor_x", int'(out_tdata[11:0]), -1);
      end else begin
        want = expected_cursor.pop_front();
        if (out_tdata[11:0] !== want.x)
          report_mismatch("cursor_x", int'(out_tdata[11:0]), int'(want.x));
        if (out_tdata[23:12] !== want.y)
          report_mismatch("cursor_y", int'(out_tdata[23:12]), int'(want.y));
        if (out_tdata[26:24] !== want.buttons)
          report_mismatch("button_bits", int'(out_tdata[26:24]), int'(want.buttons));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, expected_cursor.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= ps2mc_pkg::REG_SCREEN_WIDTH;
    cfg_wdata  <= '0;
    rst_n      <= 1'b0;
    pkt_phase   = ps2mc_pkg::PH_FLAGS;
    held_flags  = '0;
    held_x      = '0;
    cur_x       = ps2mc_pkg::CURSOR_W'(ps2mc_pkg::POS_X_RST);
    cur_y       = ps2mc_pkg::CURSOR_W'(ps2mc_pkg::POS_Y_RST);
    cur_buttons = '0;
    screen_w_q  = ps2mc_pkg::SCREEN_WIDTH_RST;
    screen_h_q  = ps2mc_pkg::SCREEN_HEIGHT_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_and_sync();
    test_delta_extremes();
    test_overflow_packets();
    test_random_traffic();
    test_output_stall();
    test_screen_bounds();
    wait_drained();
    repeat (5) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- ps2_mouse_packet_cursor.f -----
rtl/ps2mc_pkg.sv
rtl/ps2_mouse_packet_cursor.sv
dv/testbench.sv
